// File: rtl/necfd_pkg.sv
// Shared types, register indexes and helpers for the NEC IR frame decoder.
// No dependencies; every other rtl file uses it by scoped name.
`timescale 1ns / 1ps

package necfd_pkg;

  // Field widths
  localparam int unsigned DurW   = 15;
  localparam int unsigned CountW = 7;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned IdxW   = 3;

  // Saturation limit of the per-frame symbol counter
  localparam logic [CountW-1:0] MaxSymbols = CountW'(64);
  // Last symbol index that still carries a code bit
  localparam logic [CountW-1:0] CodeBits   = CountW'(32);

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegLongMarkCenter     = 3'd0;
  localparam logic [IdxW-1:0] RegLongMarkTol        = 3'd1;
  localparam logic [IdxW-1:0] RegStartSpaceCenter   = 3'd2;
  localparam logic [IdxW-1:0] RegStartSpaceTol      = 3'd3;
  localparam logic [IdxW-1:0] RegRepeatSpaceCenter  = 3'd4;
  localparam logic [IdxW-1:0] RegRepeatSpaceTol     = 3'd5;
  localparam logic [IdxW-1:0] RegOneBitThreshold    = 3'd6;
  localparam logic [IdxW-1:0] RegMinFrameSymbols    = 3'd7;

  // Frame kinds decided by the first symbol
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindLeader = 2'd1;
  localparam logic [1:0] KindRepeat = 2'd2;

  // One captured symbol
  typedef struct packed {
    logic [DurW-1:0] first_duration;
    logic [DurW-1:0] second_duration;
    logic            frame_end;
  } sym_word_t;

  // One decoded frame result
  typedef struct packed {
    logic             code_valid;
    logic             repeat_frame;
    logic [CodeW-1:0] ir_code;
  } res_word_t;

  // Live configuration
  typedef struct packed {
    logic [DurW-1:0]   long_mark_center;
    logic [DurW-1:0]   long_mark_tolerance;
    logic [DurW-1:0]   start_space_center;
    logic [DurW-1:0]   start_space_tolerance;
    logic [DurW-1:0]   repeat_space_center;
    logic [DurW-1:0]   repeat_space_tolerance;
    logic [DurW-1:0]   one_bit_threshold;
    logic [CountW-1:0] min_frame_symbols;
  } cfg_t;

  // True when c - t <= v <= c + t, evaluated one bit wider so nothing wraps
  function automatic logic near_value(logic [DurW-1:0] v, logic [DurW-1:0] c,
                                      logic [DurW-1:0] t);
    logic [DurW:0] lo_sum;
    logic [DurW:0] hi_sum;
    lo_sum = {1'b0, v} + {1'b0, t};
    hi_sum = {1'b0, c} + {1'b0, t};
    return (lo_sum >= {1'b0, c}) && ({1'b0, v} <= hi_sum);
  endfunction

endpackage

// File: rtl/necfd_cfg_regs.sv
// Configuration register bank of the NEC IR frame decoder.
// Depends on necfd_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module necfd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [necfd_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [necfd_pkg::DurW-1:0] cfg_wdata_i,
  output necfd_pkg::cfg_t            cfg_o
);

  necfd_pkg::cfg_t cfg_q;
  necfd_pkg::cfg_t cfg_d;

  // Decode the write into the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        necfd_pkg::RegLongMarkCenter:    cfg_d.long_mark_center       = cfg_wdata_i;
        necfd_pkg::RegLongMarkTol:       cfg_d.long_mark_tolerance    = cfg_wdata_i;
        necfd_pkg::RegStartSpaceCenter:  cfg_d.start_space_center     = cfg_wdata_i;
        necfd_pkg::RegStartSpaceTol:     cfg_d.start_space_tolerance  = cfg_wdata_i;
        necfd_pkg::RegRepeatSpaceCenter: cfg_d.repeat_space_center    = cfg_wdata_i;
        necfd_pkg::RegRepeatSpaceTol:    cfg_d.repeat_space_tolerance = cfg_wdata_i;
        necfd_pkg::RegOneBitThreshold:   cfg_d.one_bit_threshold      = cfg_wdata_i;
        necfd_pkg::RegMinFrameSymbols:
          cfg_d.min_frame_symbols = cfg_wdata_i[necfd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Hold registers, load protocol defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_mark_center       <= necfd_pkg::DurW'(9000);
      cfg_q.long_mark_tolerance    <= necfd_pkg::DurW'(1200);
      cfg_q.start_space_center     <= necfd_pkg::DurW'(4500);
      cfg_q.start_space_tolerance  <= necfd_pkg::DurW'(800);
      cfg_q.repeat_space_center    <= necfd_pkg::DurW'(2250);
      cfg_q.repeat_space_tolerance <= necfd_pkg::DurW'(600);
      cfg_q.one_bit_threshold      <= necfd_pkg::DurW'(1000);
      cfg_q.min_frame_symbols      <= necfd_pkg::CountW'(34);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/necfd_frame.sv
// Frame state and decode logic: classifies the leader symbol, shifts in
// data bits and forms the frame result. Depends on necfd_pkg.
`timescale 1ns / 1ps

module necfd_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  necfd_pkg::cfg_t      cfg_i,
  input  logic                 step_i,
  input  necfd_pkg::sym_word_t sym_i,
  output necfd_pkg::res_word_t res_o
);

  logic [necfd_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic [1:0]                   kind_q, kind_d, kind_cur;
  logic [necfd_pkg::CodeW-1:0]  shift_q, shift_d, shift_cur;
  logic [necfd_pkg::CodeW-1:0]  last_q, last_d;
  logic                         l0, l1, is_leader, rep_hdr;
  logic [necfd_pkg::DurW-1:0]   longer;
  logic                         data_bit;
  logic                         len_ok;

  // Classify the first symbol of a frame
  always_comb begin
    l0 = necfd_pkg::near_value(sym_i.first_duration, cfg_i.long_mark_center,
                               cfg_i.long_mark_tolerance);
    l1 = necfd_pkg::near_value(sym_i.second_duration, cfg_i.long_mark_center,
                               cfg_i.long_mark_tolerance);
    is_leader =
      (l0 && necfd_pkg::near_value(sym_i.second_duration, cfg_i.start_space_center,
                                   cfg_i.start_space_tolerance)) ||
      (l1 && necfd_pkg::near_value(sym_i.first_duration, cfg_i.start_space_center,
                                   cfg_i.start_space_tolerance));
    rep_hdr =
      (l0 && necfd_pkg::near_value(sym_i.second_duration, cfg_i.repeat_space_center,
                                   cfg_i.repeat_space_tolerance)) ||
      (l1 && necfd_pkg::near_value(sym_i.first_duration, cfg_i.repeat_space_center,
                                   cfg_i.repeat_space_tolerance));
  end

  // Data bit from the longer of the two durations
  assign longer   = (sym_i.first_duration > sym_i.second_duration) ?
                    sym_i.first_duration : sym_i.second_duration;
  assign data_bit = longer > cfg_i.one_bit_threshold;

  // Update kind, shift register and saturating count for this symbol
  always_comb begin
    if (count_q == '0) begin
      kind_cur  = is_leader ? necfd_pkg::KindLeader :
                  (rep_hdr ? necfd_pkg::KindRepeat : necfd_pkg::KindNone);
      shift_cur = '0;
    end else begin
      kind_cur  = kind_q;
      shift_cur = (count_q <= necfd_pkg::CodeBits) ?
                  {shift_q[necfd_pkg::CodeW-2:0], data_bit} : shift_q;
    end
    count_inc = (count_q < necfd_pkg::MaxSymbols) ? count_q + 1'b1 : count_q;
    len_ok    = count_inc >= cfg_i.min_frame_symbols;
  end

  // Form the result and the next state
  always_comb begin
    res_o   = '0;
    count_d = count_inc;
    kind_d  = kind_cur;
    shift_d = shift_cur;
    last_d  = last_q;
    if (sym_i.frame_end) begin
      count_d = '0;
      kind_d  = necfd_pkg::KindNone;
      shift_d = '0;
      if (len_ok && kind_cur == necfd_pkg::KindLeader) begin
        res_o.code_valid = 1'b1;
        res_o.ir_code    = shift_cur;
        last_d           = shift_cur;
      end else if (len_ok && kind_cur == necfd_pkg::KindRepeat && last_q != '0) begin
        res_o.code_valid   = 1'b1;
        res_o.repeat_frame = 1'b1;
        res_o.ir_code      = last_q;
      end
    end
  end

  // Advance state only when the symbol leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kind_q  <= necfd_pkg::KindNone;
      shift_q <= '0;
      last_q  <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      kind_q  <= kind_d;
      shift_q <= shift_d;
      last_q  <= last_d;
    end
  end

endmodule

// File: rtl/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder: input register, frame logic and
// result register. Depends on necfd_pkg, necfd_cfg_regs and necfd_frame.
//
//  port group   dir  handshake              word
//  in_*         in   in_valid_i/in_ready_o  sym_word_t (two durations, frame end)
//  out_*        out  out_valid_o/out_ready_i res_word_t (valid, repeat, code)
//  cfg_*        in   cfg_we_i               index cfg_idx_i, data cfg_wdata_i
//
// One symbol per cycle unless a frame-end symbol waits on a stalled output;
// a result is formed from the input register straight into the result register.
// Reset is asynchronous and active low; it clears the frame state, the stored last
// code and the valid flags of both registers, and loads the default timing values.
// A stalled output blocks only a frame-end symbol in the input register;
// symbols without a result keep flowing past a waiting result word.
`timescale 1ns / 1ps

module nec_ir_frame_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  necfd_pkg::sym_word_t       in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output necfd_pkg::res_word_t       out_word_o,
  input  logic                       cfg_we_i,
  input  logic [necfd_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [necfd_pkg::DurW-1:0] cfg_wdata_i
);

  necfd_pkg::cfg_t      cfg;
  necfd_pkg::sym_word_t in_word_q;
  necfd_pkg::res_word_t out_word_q;
  necfd_pkg::res_word_t res;
  logic                 in_valid_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 step;

  necfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  necfd_frame u_frame (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .step_i(step),
    .sym_i (in_word_q),
    .res_o (res)
  );

  // Advance the held symbol unless its result has nowhere to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (!in_word_q.frame_end || out_free);
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // Result register: load on a frame end, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_word_q.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_word_q.frame_end) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  // A held symbol stalls only behind an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |-> (out_valid_q && !out_ready_i))
    else $error("input stage stalled without a blocked result");

  // A repeat result always carries a nonzero stored code
  a_repeat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.repeat_frame) |->
      (out_word_q.code_valid && out_word_q.ir_code != '0))
    else $error("repeat result without a valid stored code");

  // A rejected frame gives an all-zero word
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_word_q.code_valid) |->
      (!out_word_q.repeat_frame && out_word_q.ir_code == '0))
    else $error("rejected result carries a code");

  // A result appears only after a frame-end symbol left the input stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && in_word_q.frame_end))
    else $error("result appeared without a frame end");
`endif

endmodule
